[src/nmxh_pkg.sv]
// Shared constants, codes and control structs for the n-gram multiply/xor hasher.
`default_nettype none
package nmxh_pkg;

  localparam int NMXH_HEADS = 2;

  localparam int TOKEN_W    = 32;
  localparam int MULT_W     = 64;
  localparam int PAD_W      = 32;
  localparam int MOD_W      = 32;
  localparam int HIST_W     = 33;
  localparam int BUCKET_W   = 32;
  localparam int MIX_W      = 64;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BIT_CNT_W  = 6;
  localparam int OUT_DATA_W = 4 * BUCKET_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MULT_CUR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_PREV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULT_PRV2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOKEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BI_MOD_A  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BI_MOD_B  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_MOD_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_MOD_B = 3'd7;

  // multiply operand: which token feeds the shared 32x32 multiplier
  localparam logic [1:0] OPND_TOKEN = 2'd0;
  localparam logic [1:0] OPND_HIST1 = 2'd1;
  localparam logic [1:0] OPND_HIST2 = 2'd2;

  // partial product: lo*lo, lo*hi, hi*lo (hi*hi drops out mod 2^64)
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HL = 2'd2;

  // remainder being computed
  localparam logic [1:0] SEL_BI_A  = 2'd0;
  localparam logic [1:0] SEL_BI_B  = 2'd1;
  localparam logic [1:0] SEL_TRI_A = 2'd2;
  localparam logic [1:0] SEL_TRI_B = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_issue;
    logic [1:0] mul_opnd;
    logic [1:0] mul_part;
    logic       div_start;
    logic       div_step;
    logic       div_fin;
    logic [1:0] div_sel;
    logic       out_load;
  } nmxh_cmd_t;

  typedef struct packed {
    logic out_free;
  } nmxh_stat_t;

endpackage
`default_nettype wire

[src/nmxh_dp.sv]
// Datapath: config registers, history, shared multiplier, serial divider, output register.
`default_nettype none
module nmxh_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nmxh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nmxh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [nmxh_pkg::TOKEN_W-1:0]    s_tdata,
  input  wire logic                            s_tuser,
  input  wire logic                            m_tready,
  output logic                                 m_tvalid,
  output logic [nmxh_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  wire nmxh_pkg::nmxh_cmd_t             cmd,
  output nmxh_pkg::nmxh_stat_t                 stat
);
  import nmxh_pkg::*;

  logic [MULT_W-1:0]   mult_cur, mult_prev, mult_prv2;
  logic [PAD_W-1:0]    pad_token;
  logic [MOD_W-1:0]    bi_mod_a, bi_mod_b, tri_mod_a, tri_mod_b;

  logic [HIST_W-1:0]   hist_one, hist_two;
  logic [HIST_W-1:0]   pad_hist, h1_use, h2_use;
  logic [TOKEN_W-1:0]  op_tok;
  logic [HIST_W-1:0]   op_h1, op_h2;

  logic [HALF_W-1:0]   a_lo, a_hi, mul_x, mul_y;
  logic [MULT_W-1:0]   mul_m;
  logic [MIX_W-1:0]    prod, acc, sum_next, mix2, mix3;
  logic                pipe_valid;
  logic [1:0]          pipe_opnd, pipe_part;

  logic [MOD_W-1:0]    div_mod;
  logic [MIX_W-1:0]    div_mix, quo;
  logic                neg;
  logic [MOD_W-1:0]    rem, rem_next, rem_fixed;
  logic [MOD_W:0]      r_sh, r_sub;

  logic [BUCKET_W-1:0] bi_a, bi_b, tri_a, tri_b;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mult_cur  <= '0;
      mult_prev <= '0;
      mult_prv2 <= '0;
      pad_token <= '0;
      bi_mod_a  <= MOD_W'(1);
      bi_mod_b  <= MOD_W'(1);
      tri_mod_a <= MOD_W'(1);
      tri_mod_b <= MOD_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MULT_CUR:  mult_cur  <= cfg_data;
        REG_MULT_PREV: mult_prev <= cfg_data;
        REG_MULT_PRV2: mult_prv2 <= cfg_data;
        REG_PAD_TOKEN: pad_token <= cfg_data[PAD_W-1:0];
        REG_BI_MOD_A:  bi_mod_a  <= cfg_data[MOD_W-1:0];
        REG_BI_MOD_B:  bi_mod_b  <= cfg_data[MOD_W-1:0];
        REG_TRI_MOD_A: tri_mod_a <= cfg_data[MOD_W-1:0];
        REG_TRI_MOD_B: tri_mod_b <= cfg_data[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // history: the operands are latched and the history shifted at accept
  assign pad_hist = {pad_token[PAD_W-1], pad_token};
  assign h1_use   = s_tuser ? pad_hist : hist_one;
  assign h2_use   = s_tuser ? pad_hist : hist_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_one <= '0;
      hist_two <= '0;
    end else if (cmd.load) begin
      hist_one <= {1'b0, s_tdata};
      hist_two <= h1_use;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_tok <= s_tdata;
      op_h1  <= h1_use;
      op_h2  <= h2_use;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (cmd.mul_opnd)
      OPND_TOKEN: begin
        a_lo  = op_tok;
        a_hi  = '0;
        mul_m = mult_cur;
      end
      OPND_HIST1: begin
        a_lo  = op_h1[HALF_W-1:0];
        a_hi  = {HALF_W{op_h1[HIST_W-1]}};
        mul_m = mult_prev;
      end
      default: begin
        a_lo  = op_h2[HALF_W-1:0];
        a_hi  = {HALF_W{op_h2[HIST_W-1]}};
        mul_m = mult_prv2;
      end
    endcase
    case (cmd.mul_part)
      PART_LL: begin
        mul_x = a_lo;
        mul_y = mul_m[HALF_W-1:0];
      end
      PART_LH: begin
        mul_x = a_lo;
        mul_y = mul_m[MULT_W-1:HALF_W];
      end
      default: begin
        mul_x = a_hi;
        mul_y = mul_m[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod      <= MIX_W'(mul_x) * MIX_W'(mul_y);
    pipe_opnd <= cmd.mul_opnd;
    pipe_part <= cmd.mul_part;
  end

  always_ff @(posedge clk) begin
    if (rst) pipe_valid <= 1'b0;
    else     pipe_valid <= cmd.mul_issue;
  end

  // cross terms land in the upper half only
  assign sum_next = (pipe_part == PART_LL) ? prod
                  : acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (pipe_valid) begin
      acc <= sum_next;
      if (pipe_part == PART_HL) begin
        case (pipe_opnd)
          OPND_TOKEN: mix2 <= sum_next;
          OPND_HIST1: mix2 <= mix2 ^ sum_next;
          default:    mix3 <= mix2 ^ sum_next;
        endcase
      end
    end
  end

  // restoring divider on the magnitude, one quotient bit a cycle
  always_comb begin
    case (cmd.div_sel)
      SEL_BI_A:  div_mod = bi_mod_a;
      SEL_BI_B:  div_mod = bi_mod_b;
      SEL_TRI_A: div_mod = tri_mod_a;
      default:   div_mod = tri_mod_b;
    endcase
    div_mix   = cmd.div_sel[1] ? mix3 : mix2;
    r_sh      = {rem, quo[MIX_W-1]};
    r_sub     = r_sh - {1'b0, div_mod};
    rem_next  = (r_sh >= {1'b0, div_mod}) ? r_sub[MOD_W-1:0] : r_sh[MOD_W-1:0];
    // floored result for a negative mix
    if (div_mod == '0)           rem_fixed = '0;
    else if (neg && rem != '0)   rem_fixed = div_mod - rem;
    else                         rem_fixed = rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= div_mix[MIX_W-1] ? (~div_mix + MIX_W'(1)) : div_mix;
      neg <= div_mix[MIX_W-1];
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[MIX_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bi_a  <= '0;
      bi_b  <= '0;
      tri_a <= '0;
      tri_b <= '0;
    end else if (cmd.div_fin) begin
      case (cmd.div_sel)
        SEL_BI_A:  bi_a  <= rem_fixed;
        SEL_BI_B:  bi_b  <= rem_fixed;
        SEL_TRI_A: tri_a <= rem_fixed;
        default:   tri_b <= rem_fixed;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {tri_b, tri_a, bi_b, bi_a};
  end

  always_ff @(posedge clk) begin
    if (rst)               m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready)     m_tvalid <= 1'b0;
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire

[src/nmxh_ctrl.sv]
// Controller: sequences the partial products, the remainders and the output load.
`default_nettype none
module nmxh_ctrl #(
  parameter int HEADS = nmxh_pkg::NMXH_HEADS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire nmxh_pkg::nmxh_stat_t stat,
  output nmxh_pkg::nmxh_cmd_t       cmd
);
  import nmxh_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MUL       = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT  = 3'd2;
  localparam logic [2:0] ST_DIV_START = 3'd3;
  localparam logic [2:0] ST_DIV_RUN   = 3'd4;
  localparam logic [2:0] ST_DIV_FIN   = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  // one head: only the head-zero remainders are computed
  localparam logic [1:0] LAST_SEL = (HEADS >= 2) ? SEL_TRI_B : SEL_TRI_A;
  localparam logic [1:0] SEL_INC  = (HEADS >= 2) ? 2'd1 : 2'd2;

  logic [2:0]           state, state_next;
  logic [1:0]           opnd, opnd_next;
  logic [1:0]           part, part_next;
  logic [1:0]           sel, sel_next;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      opnd    <= OPND_TOKEN;
      part    <= PART_LL;
      sel     <= SEL_BI_A;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      opnd    <= opnd_next;
      part    <= part_next;
      sel     <= sel_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    opnd_next     = opnd;
    part_next     = part;
    sel_next      = sel;
    bit_cnt_next  = bit_cnt;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.mul_opnd  = opnd;
    cmd.mul_part  = part;
    cmd.div_sel   = sel;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          opnd_next  = OPND_TOKEN;
          part_next  = PART_LL;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_issue = 1'b1;
        if (part == PART_HL) begin
          part_next = PART_LL;
          if (opnd == OPND_HIST2) state_next = ST_MUL_WAIT;
          else                    opnd_next  = opnd + 2'd1;
        end else begin
          part_next = part + 2'd1;
        end
      end
      ST_MUL_WAIT: begin
        sel_next   = SEL_BI_A;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        bit_cnt_next  = '0;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + BIT_CNT_W'(1);
        if (bit_cnt == '1) state_next = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        if (sel == LAST_SEL) begin
          state_next = ST_DONE;
        end else begin
          sel_next   = sel + SEL_INC;
          state_next = ST_DIV_START;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/ngram_multiply_xor_hash.sv]
// Top level: n-gram bucket hasher with a multiplicative xor mix and floored remainders.
// Sequence: the partial products, a drain state, a start/step/finish pass per remainder (four
// for two heads, two for one), then the output load that raises m_tvalid; the next token can be
// taken in the cycle after, and no token is taken while an earlier one is still in flight.
// Throughput is set by the shared 64-bit restoring divider (one bit per cycle, 64 steps).
// Output is registered; a waiting result does not block the next accept.
// Synchronous reset clears history to zero, multipliers and pad to zero, moduli to one.
`default_nettype none
module ngram_multiply_xor_hash #(
  parameter int HEADS = nmxh_pkg::NMXH_HEADS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nmxh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nmxh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [nmxh_pkg::TOKEN_W-1:0]    s_tdata,   // [31:0] token
  input  wire logic                            s_tuser,   // [0] seq_start
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] bigram_bucket_a, [63:32] bigram_bucket_b,
  // [95:64] trigram_bucket_a, [127:96] trigram_bucket_b
  output logic [nmxh_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import nmxh_pkg::*;

  nmxh_cmd_t  cmd;
  nmxh_stat_t stat;

  nmxh_ctrl #(
    .HEADS (HEADS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nmxh_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output loaded over an untaken result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transaction");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

endmodule
`default_nettype wire

[dv/nmxh_bucket_checker.sv]
// Bucket checker for the n-gram hasher: tracks config writes, predicts buckets, compares results.
`timescale 1ns / 1ps
module nmxh_bucket_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nmxh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nmxh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [nmxh_pkg::TOKEN_W-1:0]    s_tdata,   // [31:0] token
  input  wire logic                            s_tuser,   // [0] seq_start
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] bigram_bucket_a, [63:32] bigram_bucket_b,
  // [95:64] trigram_bucket_a, [127:96] trigram_bucket_b
  input  wire logic [nmxh_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                                   errors,
  output int                                   pending
);
  import nmxh_pkg::*;

  typedef struct packed {
    logic [BUCKET_W-1:0] tri_b;
    logic [BUCKET_W-1:0] tri_a;
    logic [BUCKET_W-1:0] bi_b;
    logic [BUCKET_W-1:0] bi_a;
  } buckets_t;

  buckets_t bucket_q[$];
  buckets_t want;

  // shadow registers and token history (history kept in 64 bits: tokens zero-extended, pad sign-extended)
  logic [MULT_W-1:0] mult_cur, mult_prv, mult_prv2, pad_sx;
  logic [MOD_W-1:0]  mod_bi_a, mod_bi_b, mod_tri_a, mod_tri_b;
  logic [MIX_W-1:0]  hist1, hist2;

  // floored remainder of a signed 64-bit mix by an unsigned modulus
  function automatic logic [BUCKET_W-1:0] floor_mod(input logic [MIX_W-1:0] mix,
                                                     input logic [MOD_W-1:0] m);
    logic [MIX_W-1:0] mag, r;
    if (m == '0) return '0;
    if (!mix[MIX_W-1]) begin
      r = mix % {32'b0, m};
      return r[BUCKET_W-1:0];
    end
    mag = ~mix + 64'd1;
    r = mag % {32'b0, m};
    if (r == '0) return '0;
    return m - r[BUCKET_W-1:0];
  endfunction

  function automatic buckets_t predict_buckets(input logic [TOKEN_W-1:0] tok,
                                               input logic [MIX_W-1:0] h1,
                                               input logic [MIX_W-1:0] h2);
    logic [MIX_W-1:0] p0, p1, p2, bi_mix, tri_mix;
    buckets_t b;
    p0 = {32'b0, tok} * mult_cur;
    p1 = h1 * mult_prv;
    p2 = h2 * mult_prv2;
    bi_mix  = p0 ^ p1;
    tri_mix = bi_mix ^ p2;
    b.bi_a  = floor_mod(bi_mix, mod_bi_a);
    b.bi_b  = floor_mod(bi_mix, mod_bi_b);
    b.tri_a = floor_mod(tri_mix, mod_tri_a);
    b.tri_b = floor_mod(tri_mix, mod_tri_b);
    return b;
  endfunction

  task automatic check_field(input string name, input logic [BUCKET_W-1:0] exp_v,
                             input logic [BUCKET_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $error("%s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mult_cur  = '0;
      mult_prv  = '0;
      mult_prv2 = '0;
      pad_sx    = '0;
      mod_bi_a  = 32'd1;
      mod_bi_b  = 32'd1;
      mod_tri_a = 32'd1;
      mod_tri_b = 32'd1;
      hist1     = '0;
      hist2     = '0;
      bucket_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (bucket_q.size() == 0) begin
          errors++;
          $error("result with nothing expected: %h", m_tdata);
        end else begin
          want = bucket_q.pop_front();
          check_field("bigram_bucket_a",  want.bi_a,  m_tdata[31:0]);
          check_field("bigram_bucket_b",  want.bi_b,  m_tdata[63:32]);
          check_field("trigram_bucket_a", want.tri_a, m_tdata[95:64]);
          check_field("trigram_bucket_b", want.tri_b, m_tdata[127:96]);
        end
      end
      if (s_tvalid && s_tready) begin
        // sequence start resets both history slots to pad
        if (s_tuser) begin
          hist1 = pad_sx;
          hist2 = pad_sx;
        end
        bucket_q.push_back(predict_buckets(s_tdata, hist1, hist2));
        hist2 = hist1;
        hist1 = {32'b0, s_tdata};
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MULT_CUR:  mult_cur  = cfg_data;
          REG_MULT_PREV: mult_prv  = cfg_data;
          REG_MULT_PRV2: mult_prv2 = cfg_data;
          REG_PAD_TOKEN: pad_sx    = {{32{cfg_data[31]}}, cfg_data[31:0]};
          REG_BI_MOD_A:  mod_bi_a  = cfg_data[31:0];
          REG_BI_MOD_B:  mod_bi_b  = cfg_data[31:0];
          REG_TRI_MOD_A: mod_tri_a = cfg_data[31:0];
          REG_TRI_MOD_B: mod_tri_b = cfg_data[31:0];
          default: ;
        endcase
      end
    end
    pending = bucket_q.size();
  end

endmodule

[dv/tb_ngram_multiply_xor_hash.sv]
// Testbench top for the n-gram hasher: clock, reset, config phases, token stimulus and verdict.
`timescale 1ns / 1ps
module tb_ngram_multiply_xor_hash;
  import nmxh_pkg::*;

  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASES       = 10;
  localparam int PHASE_TOKENS = 175;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [TOKEN_W-1:0]    s_tdata   = '0;   // [31:0] token
  logic                  s_tuser   = 1'b0; // [0] seq_start
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [31:0] bigram_bucket_a, [63:32] bigram_bucket_b,
  // [95:64] trigram_bucket_a, [127:96] trigram_bucket_b
  logic [OUT_DATA_W-1:0] m_tdata;

  int errors;
  int pending;

  bit calm     = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;
  int hold_left = 0;
  int phase, n;

  logic [CFG_DATA_W-1:0] next_regs [8];

  always #5 clk = ~clk;

  ngram_multiply_xor_hash i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  nmxh_bucket_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  // write all eight registers back to back, starting at the current edge
  task automatic load_regs;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= next_regs[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // gaps are long and random so they land anywhere in the block's pass over a token
  task automatic send_token(input logic [TOKEN_W-1:0] tok, input logic start);
    int gap;
    gap = (!calm && $urandom_range(99) < 23) ? $urandom_range(1, 320) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tok;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid, then wait at falling edges until every expected result has come
  task automatic wait_drained;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [MULT_W-1:0] rand_mult;
    case ($urandom_range(5))
      0:       return '0;
      1:       return 64'h8000_0000_0000_0000;
      2:       return 64'h7FFF_FFFF_FFFF_FFFF;
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // upper 32 bits are junk: the block must only take the low word
  function automatic logic [CFG_DATA_W-1:0] rand_mod;
    logic [MOD_W-1:0] m;
    case ($urandom_range(7))
      0:       m = '0;
      1:       m = 32'd1;
      2:       m = '1;
      3:       m = $urandom_range(2, 16);
      4:       m = $urandom_range(1, 65536);
      default: m = $urandom;
    endcase
    return {$urandom, m};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_pad;
    logic [PAD_W-1:0] p;
    case ($urandom_range(4))
      0:       p = 32'h8000_0000;
      1:       p = 32'h7FFF_FFFF;
      2:       p = '1;
      3:       p = '0;
      default: p = $urandom;
    endcase
    return {$urandom, p};
  endfunction

  function automatic logic [TOKEN_W-1:0] rand_token;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random backpressure, plus one long hold-off counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config, no sequence start yet: history is still zero
    send_token(32'hDEAD_BEEF, 1'b0);
    send_token(32'h0000_0001, 1'b0);
    wait_drained;

    next_regs[REG_MULT_CUR]  = 64'h9E37_79B9_7F4A_7C15;
    next_regs[REG_MULT_PREV] = 64'hC2B2_AE3D_27D4_EB4F;
    next_regs[REG_MULT_PRV2] = 64'h1656_67B1_9E37_79F9;
    next_regs[REG_PAD_TOKEN] = 64'h0000_0000_8000_0000;
    next_regs[REG_BI_MOD_A]  = 64'd1_000_003;
    next_regs[REG_BI_MOD_B]  = 64'h0000_0000_FFFF_FFFF;
    next_regs[REG_TRI_MOD_A] = 64'd7;
    next_regs[REG_TRI_MOD_B] = 64'd65536;
    load_regs;
    send_token(32'h0000_0000, 1'b0);
    send_token(32'hFFFF_FFFF, 1'b0);
    send_token(32'h0000_0001, 1'b0);
    send_token(32'h8000_0000, 1'b1);
    send_token(32'h7FFF_FFFF, 1'b0);
    send_token(32'hFFFF_FFFF, 1'b0);
    send_token(32'h0000_0000, 1'b1);
    send_token(32'h0000_0000, 1'b1);
    send_token(32'h5555_AAAA, 1'b0);
    send_token(32'hFFFF_FFFF, 1'b1);
    wait_drained;

    // extreme multipliers, zero modulus, junk in the upper config bits
    next_regs[REG_MULT_CUR]  = 64'h7FFF_FFFF_FFFF_FFFF;
    next_regs[REG_MULT_PREV] = 64'h8000_0000_0000_0000;
    next_regs[REG_MULT_PRV2] = 64'hFFFF_FFFF_FFFF_FFFF;
    next_regs[REG_PAD_TOKEN] = 64'hDEAD_BEEF_7FFF_FFFF;
    next_regs[REG_BI_MOD_A]  = 64'hFFFF_FFFF_0000_0000;
    next_regs[REG_BI_MOD_B]  = 64'd1;
    next_regs[REG_TRI_MOD_A] = 64'h1234_5678_FFFF_FFFF;
    next_regs[REG_TRI_MOD_B] = 64'd2;
    load_regs;
    send_token(32'hFFFF_FFFF, 1'b1);
    send_token(32'hFFFF_FFFF, 1'b0);
    send_token(32'h0000_0000, 1'b0);
    send_token(32'hAAAA_5555, 1'b0);
    send_token(32'h0000_0001, 1'b1);
    send_token(32'h8000_0000, 1'b0);
    send_token(32'h7FFF_FFFF, 1'b0);
    send_token(32'h0000_0003, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained;
      if (phase == 0) begin
        next_regs[REG_MULT_CUR]  = '1;
        next_regs[REG_MULT_PREV] = '1;
        next_regs[REG_MULT_PRV2] = '1;
        next_regs[REG_PAD_TOKEN] = 64'h0000_0000_8000_0000;
        next_regs[REG_BI_MOD_A]  = 64'h0000_0000_FFFF_FFFF;
        next_regs[REG_BI_MOD_B]  = 64'h0000_0000_FFFF_FFFF;
        next_regs[REG_TRI_MOD_A] = 64'h0000_0000_FFFF_FFFF;
        next_regs[REG_TRI_MOD_B] = 64'h0000_0000_FFFF_FFFF;
      end else begin
        next_regs[REG_MULT_CUR]  = rand_mult();
        next_regs[REG_MULT_PREV] = rand_mult();
        next_regs[REG_MULT_PRV2] = rand_mult();
        next_regs[REG_PAD_TOKEN] = rand_pad();
        next_regs[REG_BI_MOD_A]  = rand_mod();
        next_regs[REG_BI_MOD_B]  = rand_mod();
        next_regs[REG_TRI_MOD_A] = rand_mod();
        next_regs[REG_TRI_MOD_B] = rand_mod();
      end
      load_regs;
      calm = (phase == 3);
      for (n = 0; n < PHASE_TOKENS; n++) begin
        if (phase == 5 && n == 20) hold_req = 1'b1;
        if (phase == 7 && n == 80) wait_drained;
        send_token(rand_token(), $urandom_range(7) == 0);
      end
    end

    calm = 1'b0;
    wait_drained;
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
